[hw/rtl/lzsd_pkg.sv]
// Shared types and constants of the LZSS window decompressor.
package lzsd_pkg;

    localparam int WIN_AW    = 12;
    localparam int WIN_DEPTH = 1 << WIN_AW;

    localparam logic [WIN_AW-1:0] POS_OFFSET = 12'd18;
    localparam logic [4:0]        LEN_OFFSET = 5'd3;

    // Parser phase of the compressed format.
    typedef enum logic [2:0] {
        PH_FLAG   = 3'b001,
        PH_TOKEN  = 3'b010,
        PH_MATCH2 = 3'b100
    } lzsd_phase_t;

    // One output byte issued by the sequencer toward the window.
    typedef struct packed {
        logic              valid;
        logic              rd;
        logic              wr;
        logic [7:0]        data;
        logic              byte_valid;
        logic              last_item;
        logic              eos;
        logic [WIN_AW-1:0] rd_addr;
    } lzsd_op_t;

    // One finished result leaving the window stage.
    typedef struct packed {
        logic       valid;
        logic [7:0] data;
        logic       byte_valid;
        logic       last_item;
        logic       eos;
    } lzsd_res_t;

endpackage

[hw/rtl/lzsd_window.sv]
// History window memory with fill tracking and read forwarding.
module lzsd_window (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              advance,
    input  lzsd_pkg::lzsd_op_t  op,
    output lzsd_pkg::lzsd_res_t res
);
    import lzsd_pkg::*;

    logic [7:0]        mem [WIN_DEPTH];
    logic [7:0]        q_reg;
    lzsd_op_t          st2_reg;
    logic              fwd_hit_reg;
    logic [7:0]        fwd_data_reg;
    logic              rd_ok_reg;
    logic [WIN_AW-1:0] wp_reg;
    logic              full_reg;

    logic              exec;
    logic              wr_en;
    logic              rd_en;
    logic [7:0]        res_data;

    assign exec  = advance && st2_reg.valid;
    assign wr_en = exec && st2_reg.wr;
    assign rd_en = advance && op.valid && op.rd;

    // A copied byte comes from the write in flight, from memory if the entry was
    // written in this stream, and is zero otherwise.
    always_comb begin
        if (!st2_reg.rd) begin
            res_data = st2_reg.data;
        end else if (fwd_hit_reg) begin
            res_data = fwd_data_reg;
        end else if (rd_ok_reg) begin
            res_data = q_reg;
        end else begin
            res_data = 8'd0;
        end
    end

    assign res.valid      = st2_reg.valid;
    assign res.data       = res_data;
    assign res.byte_valid = st2_reg.byte_valid;
    assign res.last_item  = st2_reg.last_item;
    assign res.eos        = st2_reg.eos;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wp_reg] <= res_data;
        end
        if (rd_en) begin
            q_reg <= mem[op.rd_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st2_reg.valid <= 1'b0;
            fwd_hit_reg   <= 1'b0;
            rd_ok_reg     <= 1'b0;
            wp_reg        <= '0;
            full_reg      <= 1'b0;
        end else begin
            if (advance) begin
                st2_reg      <= op;
                fwd_hit_reg  <= rd_en && wr_en && !st2_reg.eos && (wp_reg == op.rd_addr);
                fwd_data_reg <= res_data;
                // A stream end retiring in this cycle empties the window.
                rd_ok_reg    <= !(exec && st2_reg.eos) &&
                                (full_reg || (op.rd_addr < wp_reg));
            end
            if (exec && st2_reg.eos) begin
                wp_reg   <= '0;
                full_reg <= 1'b0;
            end else if (wr_en) begin
                wp_reg <= wp_reg + 1'b1;
                if (wp_reg == '1) begin
                    full_reg <= 1'b1;
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_fwd_only_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        fwd_hit_reg |-> (st2_reg.valid && st2_reg.rd))
        else $error("forwarding flagged for an operation that reads nothing");

    a_eos_clears_window: assert property (@(posedge aclk) disable iff (!aresetn)
        (exec && st2_reg.eos) |=> (wp_reg == '0 && !full_reg))
        else $error("window not emptied at end of stream");

    a_write_advances: assert property (@(posedge aclk) disable iff (!aresetn)
        (wr_en && !st2_reg.eos) |=> (wp_reg == $past(wp_reg) + 1'b1))
        else $error("write position did not advance after a window write");
`endif

endmodule

[hw/rtl/lzsd_seq.sv]
// Token parser and per-byte sequencer that issues window operations.
module lzsd_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_tvalid,
    input  logic [7:0]       s_tdata,
    input  logic             s_tlast,
    output logic             s_tready,
    input  logic             cfg_mode,
    input  logic             advance,
    output lzsd_pkg::lzsd_op_t op
);
    import lzsd_pkg::*;

    lzsd_phase_t       phase_reg, phase_next;
    logic [7:0]        flag_reg, flag_next;
    logic [2:0]        tok_reg, tok_next;
    logic [7:0]        held_reg, held_next;
    logic              first_reg, first_next;
    logic              mode_reg, mode_next;

    logic              busy_reg, busy_next;
    logic [4:0]        rem_reg, rem_next;
    logic [WIN_AW-1:0] addr_reg, addr_next;
    logic [7:0]        imm_a_reg, imm_a_next;
    logic [7:0]        imm_b_reg, imm_b_next;
    logic              copy_reg, copy_next;
    logic              wr_reg, wr_next;
    logic              bv_reg, bv_next;
    logic              eos_reg, eos_next;

    logic              accept;
    logic              fire;
    logic              mode_eff;
    logic [2:0]        tok_inc;
    logic              job_load;

    assign fire     = busy_reg && advance;
    assign s_tready = !busy_reg || (fire && rem_reg == 5'd1);
    assign accept   = s_tvalid && s_tready;
    assign mode_eff = first_reg ? cfg_mode : mode_reg;
    assign tok_inc  = tok_reg + 3'd1;

    assign op.valid      = busy_reg;
    assign op.rd         = copy_reg;
    assign op.wr         = wr_reg;
    assign op.data       = imm_a_reg;
    assign op.byte_valid = bv_reg;
    assign op.last_item  = (rem_reg == 5'd1);
    assign op.eos        = (rem_reg == 5'd1) && eos_reg;
    assign op.rd_addr    = addr_reg;

    always_comb begin
        phase_next = phase_reg;
        flag_next  = flag_reg;
        tok_next   = tok_reg;
        held_next  = held_reg;
        first_next = first_reg;
        mode_next  = mode_reg;
        busy_next  = busy_reg;
        rem_next   = rem_reg;
        addr_next  = addr_reg;
        imm_a_next = imm_a_reg;
        imm_b_next = imm_b_reg;
        copy_next  = copy_reg;
        wr_next    = wr_reg;
        bv_next    = bv_reg;
        eos_next   = eos_reg;
        job_load   = 1'b0;

        if (fire) begin
            rem_next   = rem_reg - 5'd1;
            addr_next  = addr_reg + 1'b1;
            imm_a_next = imm_b_reg;
            if (rem_reg == 5'd1) begin
                busy_next = 1'b0;
            end
        end

        if (accept) begin
            copy_next  = 1'b0;
            wr_next    = 1'b0;
            bv_next    = 1'b1;
            eos_next   = 1'b0;
            rem_next   = 5'd1;
            imm_a_next = s_tdata;
            imm_b_next = s_tdata;
            if (first_reg) begin
                mode_next  = cfg_mode;
                first_next = 1'b0;
            end

            if (mode_eff) begin
                case (phase_reg)
                    PH_TOKEN: begin
                        if (flag_reg[tok_reg]) begin
                            job_load   = 1'b1;
                            wr_next    = 1'b1;
                            tok_next   = tok_inc;
                            phase_next = (tok_inc == 3'd0) ? PH_FLAG : PH_TOKEN;
                        end else begin
                            held_next  = s_tdata;
                            phase_next = PH_MATCH2;
                        end
                    end
                    PH_MATCH2: begin
                        job_load   = 1'b1;
                        copy_next  = 1'b1;
                        wr_next    = 1'b1;
                        rem_next   = {1'b0, s_tdata[3:0]} + LEN_OFFSET;
                        addr_next  = {s_tdata[7:4], held_reg} + POS_OFFSET;
                        tok_next   = tok_inc;
                        phase_next = (tok_inc == 3'd0) ? PH_FLAG : PH_TOKEN;
                    end
                    default: begin
                        flag_next  = s_tdata;
                        tok_next   = 3'd0;
                        phase_next = PH_TOKEN;
                    end
                endcase
            end else if (first_reg) begin
                // The first pass-through byte waits for the second one.
                held_next = s_tdata;
            end else begin
                job_load = 1'b1;
                if (phase_reg == PH_FLAG) begin
                    imm_a_next = held_reg;
                    rem_next   = 5'd2;
                    phase_next = PH_TOKEN;
                end
            end

            if (s_tlast) begin
                if (!job_load) begin
                    job_load   = 1'b1;
                    imm_a_next = 8'd0;
                    bv_next    = 1'b0;
                end
                eos_next   = 1'b1;
                phase_next = PH_FLAG;
                flag_next  = 8'd0;
                tok_next   = 3'd0;
                held_next  = 8'd0;
                first_next = 1'b1;
            end
            busy_next = job_load;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_FLAG;
            flag_reg  <= 8'd0;
            tok_reg   <= 3'd0;
            held_reg  <= 8'd0;
            first_reg <= 1'b1;
            mode_reg  <= 1'b1;
            busy_reg  <= 1'b0;
            rem_reg   <= 5'd0;
        end else begin
            phase_reg <= phase_next;
            flag_reg  <= flag_next;
            tok_reg   <= tok_next;
            held_reg  <= held_next;
            first_reg <= first_next;
            mode_reg  <= mode_next;
            busy_reg  <= busy_next;
            rem_reg   <= rem_next;
        end
    end

    always_ff @(posedge aclk) begin
        addr_reg  <= addr_next;
        imm_a_reg <= imm_a_next;
        imm_b_reg <= imm_b_next;
        copy_reg  <= copy_next;
        wr_reg    <= wr_next;
        bv_reg    <= bv_next;
        eos_reg   <= eos_next;
    end

`ifndef NO_ASSERTIONS
    a_job_held_in_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !advance) |=> (busy_reg && $stable(rem_reg)))
        else $error("pending output job changed while the output stalled");

    a_job_has_bytes: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (rem_reg != 5'd0))
        else $error("busy sequencer with no byte left to issue");

    a_last_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && s_tlast) |=> (first_reg && phase_reg == PH_FLAG && busy_reg))
        else $error("stream end did not restart the parser");
`endif

endmodule

[hw/rtl/lzss_window_decompressor_top.sv]
// Top level of the LZSS window decompressor: ports, mode register, output register.
//
// Bytes arrive one per transfer on the s_ side, the last byte of a stream marked
// by s_tlast. An input byte that yields no output is taken without holding the
// input; one that yields output holds the input until its last output byte is
// issued, so a literal issues one byte and a match 3 to 18 bytes, paced by the
// single window memory, which is read once and written once for every copied
// byte. The next input byte is taken in the cycle the last output byte of the
// current one is issued. Output passes through the window stage register and then
// waits in an output register; while a result waits there with m_tready low, the
// byte sequencer and the window stage both hold, so an input byte can still be taken
// only when the sequencer is idle. The window is emptied at every stream end by a
// fill count, with no clearing pass. A write on the cfg port selects compressed
// decoding (1) or pass-through (0) and takes effect with the next stream's first
// byte.
module lzss_window_decompressor_top (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] in_byte
    input  logic       s_tlast,   // is_last
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] byte_valid, [1] last_of_item
    output logic       m_tlast,   // end_of_stream
    input  logic       cfg_valid,
    output logic       cfg_ready,
    input  logic       cfg_data   // compressed_mode
);
    import lzsd_pkg::*;

    logic       mode_reg;
    logic       advance;
    lzsd_op_t   op;
    lzsd_res_t  res;
    logic       m_valid_reg;
    logic [7:0] m_data_reg;
    logic [1:0] m_user_reg;
    logic       m_last_reg;

    assign cfg_ready = 1'b1;
    assign advance   = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= 1'b1;
        end else if (cfg_valid && cfg_ready) begin
            mode_reg <= cfg_data;
        end
    end

    lzsd_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .s_tready (s_tready),
        .cfg_mode (mode_reg),
        .advance  (advance),
        .op       (op)
    );

    lzsd_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .advance (advance),
        .op      (op),
        .res     (res)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= res.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= res.data;
            m_user_reg <= {res.last_item, res.byte_valid};
            m_last_reg <= res.eos;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

[verif/lzsd_check_pkg.sv]
// Scoreboard class that predicts and checks the decompressor's output bytes.
`timescale 1ns / 100ps

package lzsd_check_pkg;

    import lzsd_pkg::*;

    typedef struct {
        logic [7:0] data;
        logic       byte_valid;
        logic       last_item;
        logic       eos;
    } dec_byte_t;

    class decoded_byte_board;

        dec_byte_t         expected_bytes[$];
        dec_byte_t         item_bytes[$];
        logic [7:0]        window[WIN_DEPTH];
        logic [WIN_AW-1:0] wr_pos;
        logic [7:0]        flags;
        logic [2:0]        tok_idx;
        lzsd_phase_t       phase;
        logic [7:0]        held_lo;
        bit                first_byte;
        bit                mode_reg;
        bit                stream_mode;
        int                errors;
        int                checked;

        function new();
            mode_reg    = 1'b1;
            stream_mode = 1'b1;
            errors      = 0;
            checked     = 0;
            restart();
        endfunction

        function void restart();
            foreach (window[i]) window[i] = 8'h00;
            wr_pos     = '0;
            flags      = 8'h00;
            tok_idx    = 3'd0;
            phase      = PH_FLAG;
            held_lo    = 8'h00;
            first_byte = 1'b1;
        endfunction

        // The register only matters at the first byte of the next stream.
        function void set_mode(bit m);
            mode_reg = m;
        endfunction

        function void emit(logic [7:0] b, logic bv);
            dec_byte_t r;
            r.data       = b;
            r.byte_valid = bv;
            r.last_item  = 1'b0;
            r.eos        = 1'b0;
            item_bytes.insert(item_bytes.size(), r);
        endfunction

        function void next_token();
            tok_idx = tok_idx + 3'd1;
            phase   = (tok_idx == 3'd0) ? PH_FLAG : PH_TOKEN;
        endfunction

        function void decode_byte(logic [7:0] b);
            int                len;
            logic [WIN_AW-1:0] src;
            logic [7:0]        v;
            case (phase)
                PH_TOKEN: begin
                    if (flags[tok_idx]) begin
                        window[wr_pos] = b;
                        wr_pos = wr_pos + 1'b1;
                        emit(b, 1'b1);
                        next_token();
                    end else begin
                        held_lo = b;
                        phase   = PH_MATCH2;
                    end
                end
                PH_MATCH2: begin
                    len = int'(b[3:0]) + int'(LEN_OFFSET);
                    src = {b[7:4], held_lo} + POS_OFFSET;
                    // Byte by byte, so an overlapping copy sees its own output.
                    for (int j = 0; j < len; j++) begin
                        v = window[src + WIN_AW'(j)];
                        window[wr_pos + WIN_AW'(j)] = v;
                        emit(v, 1'b1);
                    end
                    wr_pos = wr_pos + WIN_AW'(len);
                    next_token();
                end
                default: begin
                    flags   = b;
                    tok_idx = 3'd0;
                    phase   = PH_TOKEN;
                end
            endcase
        endfunction

        function void note_input(logic [7:0] b, bit last);
            item_bytes.delete();
            if (first_byte) begin
                stream_mode = mode_reg;
                first_byte  = 1'b0;
                if (stream_mode) decode_byte(b);
                else held_lo = b;
            end else if (stream_mode) begin
                decode_byte(b);
            end else begin
                // Pass-through holds the first byte back until the second one.
                if (phase == PH_FLAG) begin
                    emit(held_lo, 1'b1);
                    phase = PH_TOKEN;
                end
                emit(b, 1'b1);
            end
            if (last) begin
                if (item_bytes.size() == 0) emit(8'h00, 1'b0);
                item_bytes[item_bytes.size()-1].eos = 1'b1;
                restart();
            end
            if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].last_item = 1'b1;
            foreach (item_bytes[i]) expected_bytes.insert(expected_bytes.size(), item_bytes[i]);
        endfunction

        function void compare_field(string name, int exp_v, int act_v);
            if (exp_v != act_v) begin
                errors++;
                $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
            end
        endfunction

        function void check_output(logic [7:0] data, logic bv, logic li, logic eos);
            dec_byte_t e;
            checked++;
            if (expected_bytes.size() == 0) begin
                errors++;
                $display("%0t: unexpected output byte %02h (valid %0b last %0b eos %0b)",
                         $time, data, bv, li, eos);
                return;
            end
            e = expected_bytes.pop_front();
            compare_field("out_byte", e.data, data);
            compare_field("byte_valid", e.byte_valid, bv);
            compare_field("last_of_item", e.last_item, li);
            compare_field("end_of_stream", e.eos, eos);
        endfunction

    endclass

endpackage

[verif/lzss_window_decompressor_top_test.sv]
// Top-level testbench of the LZSS window decompressor: stimulus, handshakes and final verdict.
`timescale 1ns / 100ps

module lzss_window_decompressor_top_test;

    import lzsd_pkg::*;
    import lzsd_check_pkg::*;

    localparam int STALL_LIMIT = 2000;

    logic       aclk      = 1'b0;
    logic       aresetn   = 1'b0;
    logic       s_tvalid  = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata   = 8'h00;
    logic       s_tlast   = 1'b0;
    logic       m_tvalid;
    logic       m_tready  = 1'b0;
    logic [7:0] m_tdata;
    logic [1:0] m_tuser;
    logic       m_tlast;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic       cfg_data  = 1'b0;

    decoded_byte_board sb = new();

    logic [7:0] stream_bytes[$];
    int         src_idle_pct = 0;
    int         snk_idle_pct = 0;
    int         items_sent   = 0;
    int         streams_sent = 0;
    int         stall_cnt    = 0;
    bit         cur_mode     = 1'b1;

    lzss_window_decompressor_top uut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always #2 aclk = ~aclk;

    always @(negedge aclk) begin
        if (aresetn) m_tready = ($urandom_range(99) >= snk_idle_pct);
    end

    // Result checking and the no-progress watchdog.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_output(m_tdata, m_tuser[0], m_tuser[1], m_tlast);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                stall_cnt = 0;
            else
                stall_cnt++;
            if (stall_cnt >= STALL_LIMIT) begin
                $display("%0t: no transfer for %0d cycles, %0d results outstanding",
                         $time, STALL_LIMIT, sb.expected_bytes.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    task automatic push_byte(logic [7:0] b, bit last);
        while ($urandom_range(99) < src_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = b;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        sb.note_input(b, last);
        items_sent++;
        @(negedge aclk);
    endtask

    task automatic send_stream(bit close);
        foreach (stream_bytes[i]) push_byte(stream_bytes[i], close && (i == stream_bytes.size()-1));
        if (close) streams_sent++;
    endtask

    // An item that yields nothing may still be in flight when the queue runs dry.
    task automatic wait_idle();
        s_tvalid = 1'b0;
        while (sb.expected_bytes.size() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_mode(bit m);
        wait_idle();
        cfg_valid = 1'b1;
        cfg_data  = m;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_mode(m);
        cur_mode = m;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Well-formed token groups; matches mostly reach back into bytes already written.
    task automatic build_compressed();
        int         n_tok;
        int         wp;
        int         d;
        logic [7:0] flag;
        logic [11:0] pos;
        logic [11:0] code;
        logic [3:0] len_code;
        stream_bytes.delete();
        wp    = 0;
        n_tok = ($urandom_range(9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 14);
        for (int t = 0; t < n_tok; t++) begin
            if (t % 8 == 0) begin
                flag = 8'($urandom);
                stream_bytes.insert(stream_bytes.size(), flag);
            end
            if (flag[3'(t)]) begin
                stream_bytes.insert(stream_bytes.size(), 8'($urandom));
                wp++;
            end else begin
                if (wp > 0 && $urandom_range(3) != 0) begin
                    d   = $urandom_range(1, (wp < 64) ? wp : 64);
                    pos = 12'(wp - d);
                end else begin
                    pos = 12'($urandom);
                end
                code     = pos - POS_OFFSET;
                len_code = 4'($urandom);
                stream_bytes.insert(stream_bytes.size(), code[7:0]);
                stream_bytes.insert(stream_bytes.size(), {code[11:8], len_code});
                wp += int'(len_code) + int'(LEN_OFFSET);
            end
        end
    endtask

    task automatic build_noise(int max_len);
        int n;
        stream_bytes.delete();
        n = $urandom_range(1, max_len);
        repeat (n) stream_bytes.insert(stream_bytes.size(), 8'($urandom));
    endtask

    task automatic run_random(int n_items);
        int  stop;
        int  r;
        int  cut;
        bit  want;
        stop = items_sent + n_items;
        while (items_sent < stop) begin
            r    = $urandom_range(99);
            want = (r >= 20);
            if (want != cur_mode || $urandom_range(4) == 0) write_mode(want);
            if (r < 20) begin
                build_noise(12);
            end else if (r < 30) begin
                build_noise(10);
            end else begin
                build_compressed();
                // A share of compressed streams is cut short anywhere, which can leave a broken last token.
                if ($urandom_range(99) < 15) begin
                    cut = $urandom_range(1, stream_bytes.size());
                    while (stream_bytes.size() > cut) void'(stream_bytes.pop_back());
                end
            end
            send_stream(1'b1);
        end
    endtask

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        src_idle_pct = 22;
        snk_idle_pct = 83;

        // One-byte stream: only an empty end marker.
        stream_bytes = '{8'h00};
        send_stream(1'b1);
        // Literal, full-length overlapping match wrapping to position zero,
        // shortest match, literals, then a match cut after its first byte.
        stream_bytes = '{8'hF5, 8'hA5, 8'hEE, 8'hFF, 8'hFF, 8'h00, 8'h00,
                         8'h5A, 8'hC3, 8'h3C, 8'h81, 8'h00, 8'h10};
        send_stream(1'b1);
        // Stream that ends on its flag byte.
        stream_bytes = '{8'h12};
        send_stream(1'b1);

        write_mode(1'b0);
        stream_bytes = '{8'h7E};
        send_stream(1'b1);
        // A mode write in the middle of a stream waits for the next stream.
        stream_bytes = '{8'h01, 8'h80};
        send_stream(1'b0);
        write_mode(1'b1);
        stream_bytes = '{8'hFF, 8'h00};
        send_stream(1'b1);
        stream_bytes = '{8'hFF, 8'h00};
        send_stream(1'b1);

        run_random(100);
        src_idle_pct = 83;
        snk_idle_pct = 22;
        run_random(120);
        src_idle_pct = 0;
        snk_idle_pct = 0;
        run_random(120);

        wait_idle();
        repeat (10) @(posedge aclk);
        $display("Sent %0d input bytes in %0d streams across both modes; checked %0d results.",
                 items_sent, streams_sent, sb.checked);
        $display("Covered truncated tokens, short streams and three back-pressure profiles.");
        if (sb.errors == 0 && sb.expected_bytes.size() == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
